@@ hdl/dwd_pkg.sv @@
// Shared types and constants for the bounded double-ended queue.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package dwd_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int WORD_W   = 32;
    localparam int CMD_W    = 3;
    localparam int STAT_W   = 2;
    localparam int OCC_W    = 5;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [CMD_W-1:0]         cmd_t;
    typedef logic [STAT_W-1:0]        stat_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [OCC_W-1:0]         occ_t;

    localparam cmd_t CMD_PUSH_BACK  = 3'd0;
    localparam cmd_t CMD_POP_BACK   = 3'd1;
    localparam cmd_t CMD_PUSH_FRONT = 3'd2;
    localparam cmd_t CMD_POP_FRONT  = 3'd3;
    localparam cmd_t CMD_DELETE     = 3'd4;

    localparam stat_t ST_DONE  = 2'd0;
    localparam stat_t ST_EMPTY = 2'd1;
    localparam stat_t ST_FULL  = 2'd2;
    localparam stat_t ST_MISS  = 2'd3;

    localparam word_t NO_WORD = -32'sd1;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;   // capture the incoming item
        logic exec;   // apply the captured item and load the result register
    } dwd_ctl_t;

endpackage

`default_nettype wire

@@ hdl/dwd_cmd_if.sv @@
// Command channel: valid/ready handshake carrying one queue command.
// Depends on dwd_pkg.
`default_nettype none

interface dwd_cmd_if import dwd_pkg::*; ();
    logic  valid;
    logic  ready;
    cmd_t  command;
    word_t value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

`default_nettype wire

@@ hdl/dwd_rsp_if.sv @@
// Response channel: valid/ready handshake carrying one command result.
// Depends on dwd_pkg.
`default_nettype none

interface dwd_rsp_if import dwd_pkg::*; ();
    logic  valid;
    logic  ready;
    word_t popped_value;
    stat_t status;
    occ_t  occupancy;
    logic  is_empty;

    modport source (output valid, output popped_value, output status,
                    output occupancy, output is_empty, input ready);
    modport sink   (input valid, input popped_value, input status,
                    input occupancy, input is_empty, output ready);
endinterface

`default_nettype wire

@@ hdl/dwd_ctrl.sv @@
// Two-state controller: accept an item, then execute it once the result
// register is free. Owns the result valid flag. Depends on dwd_pkg.
`default_nettype none

module dwd_ctrl import dwd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output dwd_ctl_t  ctl
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic exec;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    // execute only when the result register is empty or drains this cycle
    assign exec      = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);

    assign ctl.load = in_valid && in_ready;
    assign ctl.exec = exec;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (exec)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (exec)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/dwd_datapath.sv @@
// Datapath: a row of word cells ordered head to tail, the fill count,
// parallel match logic and the result register. Depends on dwd_pkg.
`default_nettype none

module dwd_datapath import dwd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire dwd_ctl_t ctl,
    input  wire cmd_t     in_command,
    input  wire word_t    in_value,
    output word_t         popped_value,
    output stat_t         status,
    output occ_t          occupancy,
    output logic          is_empty
);

    cmd_t  cmd_reg;
    word_t val_reg;
    word_t cells_reg [CAPACITY];
    word_t cells_next [CAPACITY];
    cnt_t  count_reg, count_next;
    word_t popped_reg, popped_next;
    stat_t status_reg, status_next;
    occ_t  occ_reg;
    logic  empty_reg;

    cnt_t                count_m1;
    word_t               tail_word;
    logic [CAPACITY-1:0] hit;
    logic [CAPACITY-1:0] hit_from;
    logic                is_zero;
    logic                is_full;
    logic                head_hit;
    logic                tail_hit;

    always_comb
    begin
        count_m1  = count_reg - cnt_t'(1);
        tail_word = cells_reg[count_m1[IDX_W-1:0]];
        is_zero   = (count_reg == '0);
        is_full   = (count_reg == cnt_t'(CAPACITY));
        for (int i = 0; i < CAPACITY; i++)
            hit[i] = (cells_reg[i] == val_reg) && (cnt_t'(i) < count_reg);
        // cells at and above the first match move down one place
        hit_from[0] = hit[0];
        for (int i = 1; i < CAPACITY; i++)
            hit_from[i] = hit_from[i-1] | hit[i];
        head_hit = !is_zero && hit[0];
        tail_hit = !is_zero && (tail_word == val_reg);
    end

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
            cells_next[i] = cells_reg[i];
        count_next  = count_reg;
        popped_next = NO_WORD;
        status_next = ST_DONE;

        unique case (cmd_reg)
            CMD_PUSH_BACK:
            begin
                if (is_full)
                    status_next = ST_FULL;
                else
                begin
                    cells_next[count_reg[IDX_W-1:0]] = val_reg;
                    count_next = count_reg + cnt_t'(1);
                end
            end
            CMD_POP_BACK:
            begin
                if (is_zero)
                    status_next = ST_EMPTY;
                else
                begin
                    popped_next = tail_word;
                    count_next  = count_m1;
                end
            end
            CMD_PUSH_FRONT:
            begin
                if (is_full)
                    status_next = ST_FULL;
                else
                begin
                    for (int i = 1; i < CAPACITY; i++)
                        cells_next[i] = cells_reg[i-1];
                    cells_next[0] = val_reg;
                    count_next = count_reg + cnt_t'(1);
                end
            end
            CMD_POP_FRONT:
            begin
                if (is_zero)
                    status_next = ST_EMPTY;
                else
                begin
                    popped_next = cells_reg[0];
                    for (int i = 0; i < CAPACITY - 1; i++)
                        cells_next[i] = cells_reg[i+1];
                    count_next = count_m1;
                end
            end
            CMD_DELETE:
            begin
                priority if (is_zero)
                    status_next = ST_EMPTY;
                else if (head_hit)
                begin
                    for (int i = 0; i < CAPACITY - 1; i++)
                        cells_next[i] = cells_reg[i+1];
                    count_next = count_m1;
                end
                else if (tail_hit)
                    count_next = count_m1;
                else if (|hit)
                begin
                    for (int i = 0; i < CAPACITY - 1; i++)
                        if (hit_from[i])
                            cells_next[i] = cells_reg[i+1];
                    count_next = count_m1;
                end
                else
                    status_next = ST_MISS;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // payload: no reset
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= in_command;
            val_reg <= in_value;
        end
        if (ctl.exec)
        begin
            for (int i = 0; i < CAPACITY; i++)
                cells_reg[i] <= cells_next[i];
            popped_reg <= popped_next;
            status_reg <= status_next;
            occ_reg    <= occ_t'(count_next);
            empty_reg  <= (count_next == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (ctl.exec)
            count_reg <= count_next;
    end

    assign popped_value = popped_reg;
    assign status       = status_reg;
    assign occupancy    = occ_reg;
    assign is_empty     = empty_reg;

endmodule

`default_nettype wire

@@ hdl/deque_with_delete_by_value_top.sv @@
// Top level of the bounded double-ended queue with delete by value.
// Depends on dwd_pkg, dwd_cmd_if, dwd_rsp_if, dwd_ctrl and dwd_datapath.
//
//   channel | dir | handshake    | payload
//   --------+-----+--------------+---------------------------------------------
//   cmd     | in  | valid/ready  | command, value
//   rsp     | out | valid/ready  | popped_value, status, occupancy, is_empty
//
// Each item is accepted first and then executed in the cell row, where all
// entries are compared and compacted in parallel. Execution waits while
// the previous result is still unread, so rsp stalls back up into cmd;
// the next item is accepted while a result waits. Reset clears the fill
// count and the controller; cell contents are left as they are and are
// only read below the fill count.
`default_nettype none

module deque_with_delete_by_value_top import dwd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    dwd_cmd_if.sink   cmd,
    dwd_rsp_if.source rsp
);

    dwd_ctl_t ctl;

    dwd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .ctl       (ctl)
    );

    dwd_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .in_command   (cmd.command),
        .in_value     (cmd.value),
        .popped_value (rsp.popped_value),
        .status       (rsp.status),
        .occupancy    (rsp.occupancy),
        .is_empty     (rsp.is_empty)
    );

endmodule

`default_nettype wire

@@ hdl/dwd_checker.sv @@
// Port-level checks for the double-ended queue top level, attached by bind.
// Depends on dwd_pkg and deque_with_delete_by_value_top.
`default_nettype none

module dwd_checker import dwd_pkg::*;
(
    input wire logic  clk,
    input wire logic  rst_n,
    input wire logic  rsp_valid,
    input wire logic  rsp_ready,
    input wire word_t rsp_popped_value,
    input wire stat_t rsp_status,
    input wire occ_t  rsp_occupancy,
    input wire logic  rsp_is_empty
);

    // a stalled item holds still
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_popped_value)
            && $stable(rsp_status) && $stable(rsp_occupancy))
        else $error("stalled response changed");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_is_empty == (rsp_occupancy == '0)))
        else $error("is_empty disagrees with occupancy");

    a_fail_no_word: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != ST_DONE |-> rsp_popped_value == NO_WORD)
        else $error("failed command returned a word");

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_FULL |-> rsp_occupancy == occ_t'(CAPACITY))
        else $error("full status with queue not full");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_EMPTY |-> rsp_is_empty)
        else $error("empty status with words stored");

endmodule

bind deque_with_delete_by_value_top dwd_checker u_dwd_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_popped_value (rsp.popped_value),
    .rsp_status       (rsp.status),
    .rsp_occupancy    (rsp.occupancy),
    .rsp_is_empty     (rsp.is_empty)
);

`default_nettype wire
